@@ sv/bded_pkg.sv @@
// Shared types, register codes and reset values for the baseline deviation event detector.
package bded_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int TIME_BITS_DEF   = 32;
  localparam int LEVEL_BITS      = 12;
  localparam int PERIOD_BITS     = 16;
  localparam int ADDR_BITS       = 5;
  localparam int DATA_BITS       = 32;
  localparam int RESULTS_MAX     = 3;
  localparam int COUNT_BITS      = 2;

  localparam logic [LEVEL_BITS-1:0]  RST_BASE_FIRST    = 12'd0;
  localparam logic [LEVEL_BITS-1:0]  RST_BASE_SECOND   = 12'd0;
  localparam logic [LEVEL_BITS-1:0]  RST_THRESHOLD     = 12'd200;
  localparam logic [PERIOD_BITS-1:0] RST_DEBOUNCE_TIME = 16'd50;
  localparam logic [PERIOD_BITS-1:0] RST_EVENT_GAP     = 16'd500;
  localparam logic [PERIOD_BITS-1:0] RST_RESEND_PERIOD = 16'd5000;
  localparam logic [PERIOD_BITS-1:0] RST_REPORT_PERIOD = 16'd1000;

  typedef enum logic [1:0] {
    KIND_DETECTED = 2'd0,
    KIND_CLEAR    = 2'd1,
    KIND_REPORT   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_BASE_FIRST    = 3'd0,
    REG_BASE_SECOND   = 3'd1,
    REG_THRESHOLD     = 3'd2,
    REG_DEBOUNCE_TIME = 3'd3,
    REG_EVENT_GAP     = 3'd4,
    REG_RESEND_PERIOD = 3'd5,
    REG_REPORT_PERIOD = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]  base_first;
    logic [LEVEL_BITS-1:0]  base_second;
    logic [LEVEL_BITS-1:0]  threshold;
    logic [PERIOD_BITS-1:0] debounce_time;
    logic [PERIOD_BITS-1:0] event_gap;
    logic [PERIOD_BITS-1:0] resend_period;
    logic [PERIOD_BITS-1:0] report_period;
  } cfg_t;

  // One run is every result caused by a single request; they share the payload.
  typedef struct packed {
    kind_t [RESULTS_MAX-1:0] kinds;
    logic [COUNT_BITS-1:0]   count;
    logic [LEVEL_BITS-1:0]   intensity;
    logic [LEVEL_BITS-1:0]   deviation;
    logic                    flame;
  } run_t;

endpackage

@@ sv/bded_cfg.sv @@
// Configuration register file behind the APB-style port.
module bded_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bded_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [bded_pkg::DATA_BITS-1:0]  pwdata,
  output logic [bded_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  output bded_pkg::cfg_t                  cfg
);

  bded_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = bded_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_first    <= bded_pkg::RST_BASE_FIRST;
      cfg.base_second   <= bded_pkg::RST_BASE_SECOND;
      cfg.threshold     <= bded_pkg::RST_THRESHOLD;
      cfg.debounce_time <= bded_pkg::RST_DEBOUNCE_TIME;
      cfg.event_gap     <= bded_pkg::RST_EVENT_GAP;
      cfg.resend_period <= bded_pkg::RST_RESEND_PERIOD;
      cfg.report_period <= bded_pkg::RST_REPORT_PERIOD;
    end else if (wr_en) begin
      case (idx)
        bded_pkg::REG_BASE_FIRST:    cfg.base_first    <= pwdata[bded_pkg::LEVEL_BITS-1:0];
        bded_pkg::REG_BASE_SECOND:   cfg.base_second   <= pwdata[bded_pkg::LEVEL_BITS-1:0];
        bded_pkg::REG_THRESHOLD:     cfg.threshold     <= pwdata[bded_pkg::LEVEL_BITS-1:0];
        bded_pkg::REG_DEBOUNCE_TIME: cfg.debounce_time <= pwdata[bded_pkg::PERIOD_BITS-1:0];
        bded_pkg::REG_EVENT_GAP:     cfg.event_gap     <= pwdata[bded_pkg::PERIOD_BITS-1:0];
        bded_pkg::REG_RESEND_PERIOD: cfg.resend_period <= pwdata[bded_pkg::PERIOD_BITS-1:0];
        bded_pkg::REG_REPORT_PERIOD: cfg.report_period <= pwdata[bded_pkg::PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bded_pkg::REG_BASE_FIRST:    prdata = bded_pkg::DATA_BITS'(cfg.base_first);
      bded_pkg::REG_BASE_SECOND:   prdata = bded_pkg::DATA_BITS'(cfg.base_second);
      bded_pkg::REG_THRESHOLD:     prdata = bded_pkg::DATA_BITS'(cfg.threshold);
      bded_pkg::REG_DEBOUNCE_TIME: prdata = bded_pkg::DATA_BITS'(cfg.debounce_time);
      bded_pkg::REG_EVENT_GAP:     prdata = bded_pkg::DATA_BITS'(cfg.event_gap);
      bded_pkg::REG_RESEND_PERIOD: prdata = bded_pkg::DATA_BITS'(cfg.resend_period);
      bded_pkg::REG_REPORT_PERIOD: prdata = bded_pkg::DATA_BITS'(cfg.report_period);
      default:                     prdata = '0;
    endcase
  end

endmodule

@@ sv/bded_core.sv @@
// Input register, detector state and the single-pass decision logic.
module bded_core #(
  parameter int SAMPLE_BITS = bded_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = bded_pkg::TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bded_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [SAMPLE_BITS-1:0] sample_first,
  input  logic [SAMPLE_BITS-1:0] sample_second,
  input  logic [TIME_BITS-1:0]   time_now,
  input  logic                   link_up,
  input  logic                   free,
  output logic                   load,
  output bded_pkg::run_t         run
);

  localparam int W = (SAMPLE_BITS > bded_pkg::LEVEL_BITS) ? SAMPLE_BITS : bded_pkg::LEVEL_BITS;
  localparam logic [W-1:0] SMASK = W'({SAMPLE_BITS{1'b1}});

  logic                   s1_valid;
  logic                   s1_req_type;
  logic [SAMPLE_BITS-1:0] s1_sample_first;
  logic [SAMPLE_BITS-1:0] s1_sample_second;
  logic [TIME_BITS-1:0]   s1_time_now;
  logic                   s1_link_up;

  logic                   prev_raw, prev_raw_next;
  logic                   confirmed_flame, confirmed_flame_next;
  logic                   prev_link, prev_link_next;
  logic [TIME_BITS-1:0]   raw_change_time, raw_change_time_next;
  logic [TIME_BITS-1:0]   last_event_time, last_event_time_next;
  logic [TIME_BITS-1:0]   last_detect_time, last_detect_time_next;
  logic [TIME_BITS-1:0]   last_report_time, last_report_time_next;

  logic                   accept;
  logic                   process;
  logic [W-1:0]           s_a, s_b, b_a, b_b, d_a, d_b, dev, ao;
  logic                   raw;
  logic [TIME_BITS-1:0]   el_raw, el_event, el_detect, el_report;
  logic                   link_rise;
  logic                   resend_due;
  logic [bded_pkg::COUNT_BITS-1:0] cnt;
  bded_pkg::kind_t [bded_pkg::RESULTS_MAX-1:0] kinds;

  assign process  = s1_valid && free;
  assign in_stall = s1_valid && !free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (process) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_type      <= req_type;
      s1_sample_first  <= sample_first;
      s1_sample_second <= sample_second;
      s1_time_now      <= time_now;
      s1_link_up       <= link_up;
    end
  end

  // Channel selection: the larger deviation wins, ties go to the first channel.
  assign s_a = W'(s1_sample_first);
  assign s_b = W'(s1_sample_second);
  assign b_a = W'(cfg.base_first) & SMASK;
  assign b_b = W'(cfg.base_second) & SMASK;
  assign d_a = (s_a >= b_a) ? s_a - b_a : b_a - s_a;
  assign d_b = (s_b >= b_b) ? s_b - b_b : b_b - s_b;
  assign dev = (d_a >= d_b) ? d_a : d_b;
  assign ao  = (d_a >= d_b) ? s_a : s_b;
  assign raw = dev > W'(cfg.threshold);

  assign el_raw    = s1_time_now - raw_change_time;
  assign el_event  = s1_time_now - last_event_time;
  assign el_detect = s1_time_now - last_detect_time;
  assign el_report = s1_time_now - last_report_time;

  assign link_rise = s1_link_up && !prev_link;
  // A link re-report of flame restarts the resend interval in the same step.
  assign resend_due = (link_rise && confirmed_flame) ? (cfg.resend_period == '0)
                    : (el_detect >= TIME_BITS'(cfg.resend_period));

  always_comb begin
    prev_raw_next         = prev_raw;
    confirmed_flame_next  = confirmed_flame;
    prev_link_next        = prev_link;
    raw_change_time_next  = raw_change_time;
    last_event_time_next  = last_event_time;
    last_detect_time_next = last_detect_time;
    last_report_time_next = last_report_time;
    cnt                   = '0;
    for (int i = 0; i < bded_pkg::RESULTS_MAX; i++) begin
      kinds[i] = bded_pkg::KIND_CLEAR;
    end
    if (!s1_req_type) begin
      prev_raw_next         = raw;
      confirmed_flame_next  = raw;
      last_report_time_next = s1_time_now;
      last_detect_time_next = s1_time_now;
    end else begin
      if (link_rise) begin
        if (confirmed_flame) begin
          kinds[cnt]            = bded_pkg::KIND_DETECTED;
          last_detect_time_next = s1_time_now;
        end else begin
          kinds[cnt] = bded_pkg::KIND_CLEAR;
        end
        cnt = cnt + 1'b1;
      end
      prev_link_next = s1_link_up;

      if (raw != prev_raw) begin
        prev_raw_next        = raw;
        raw_change_time_next = s1_time_now;
      end else if (el_raw >= TIME_BITS'(cfg.debounce_time)) begin
        if (raw != confirmed_flame) begin
          confirmed_flame_next = raw;
          if (el_event >= TIME_BITS'(cfg.event_gap)) begin
            last_event_time_next = s1_time_now;
            if (raw) begin
              kinds[cnt]            = bded_pkg::KIND_DETECTED;
              last_detect_time_next = s1_time_now;
            end else begin
              kinds[cnt] = bded_pkg::KIND_CLEAR;
            end
            cnt = cnt + 1'b1;
          end
        end else if (confirmed_flame && resend_due) begin
          last_detect_time_next = s1_time_now;
          kinds[cnt]            = bded_pkg::KIND_DETECTED;
          cnt                   = cnt + 1'b1;
        end
      end

      if (el_report >= TIME_BITS'(cfg.report_period)) begin
        last_report_time_next = s1_time_now;
        kinds[cnt]            = bded_pkg::KIND_REPORT;
        cnt                   = cnt + 1'b1;
      end
    end
  end

  assign load          = process && (cnt != '0);
  assign run.kinds     = kinds;
  assign run.count     = cnt;
  assign run.intensity = ao[bded_pkg::LEVEL_BITS-1:0];
  assign run.deviation = dev[bded_pkg::LEVEL_BITS-1:0];
  assign run.flame     = confirmed_flame_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw         <= 1'b0;
      confirmed_flame  <= 1'b0;
      prev_link        <= 1'b0;
      raw_change_time  <= '0;
      last_event_time  <= '0;
      last_detect_time <= '0;
      last_report_time <= '0;
    end else if (process) begin
      prev_raw         <= prev_raw_next;
      confirmed_flame  <= confirmed_flame_next;
      prev_link        <= prev_link_next;
      raw_change_time  <= raw_change_time_next;
      last_event_time  <= last_event_time_next;
      last_detect_time <= last_detect_time_next;
      last_report_time <= last_report_time_next;
    end
  end

endmodule

@@ sv/bded_out.sv @@
// Result register that holds one run and hands out its results one per cycle while out_stall is low.
module bded_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  bded_pkg::run_t                     run_in,
  output logic                               free,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         kind,
  output logic [bded_pkg::LEVEL_BITS-1:0]    intensity,
  output logic [bded_pkg::LEVEL_BITS-1:0]    deviation,
  output logic                               flame_present,
  output logic                               last_of_run
);

  logic                            run_valid;
  bded_pkg::run_t                  run;
  logic [bded_pkg::COUNT_BITS-1:0] idx;
  logic                            take;
  logic                            done;

  assign out_valid     = run_valid;
  assign kind          = run.kinds[idx];
  assign intensity     = run.intensity;
  assign deviation     = run.deviation;
  assign flame_present = run.flame;
  assign last_of_run   = (idx == run.count - 1'b1);

  assign take = run_valid && !out_stall;
  assign done = take && last_of_run;
  // The next run may be loaded in the cycle the last result of this one leaves.
  assign free = !run_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      run_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      run_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_in;
    end
  end

endmodule

@@ sv/baseline_deviation_event_detector.sv @@
// Top level of the baseline deviation event detector.
//
//   Channel  Direction  Handshake             Payload
//   in       request    in_valid / in_stall   req_type, sample_first, sample_second,
//                                             time_now, link_up
//   out      result     out_valid / out_stall kind, intensity, deviation,
//                                             flame_present, last_of_run
//   cfg      APB access psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A request is held in the input register, decided there in a single pass, and its results
// leave the result register one per cycle while out_stall is low; the first is valid once
// the run is loaded from the input register into the result register. A request with results
// holds the result register until its last result is taken, and one with none never enters it.
// Synchronous reset clears the detector state and loads the register defaults.
// A stalled result holds the result register, which in turn stalls the input.
module baseline_deviation_event_detector #(
  parameter int SAMPLE_BITS = bded_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = bded_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bded_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [bded_pkg::DATA_BITS-1:0]  pwdata,
  output logic [bded_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic [SAMPLE_BITS-1:0]          sample_first,
  input  logic [SAMPLE_BITS-1:0]          sample_second,
  input  logic [TIME_BITS-1:0]            time_now,
  input  logic                            link_up,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      kind,
  output logic [bded_pkg::LEVEL_BITS-1:0] intensity,
  output logic [bded_pkg::LEVEL_BITS-1:0] deviation,
  output logic                            flame_present,
  output logic                            last_of_run
);

  bded_pkg::cfg_t cfg;
  bded_pkg::run_t run;
  logic           load;
  logic           free;

  bded_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bded_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .sample_first  (sample_first),
    .sample_second (sample_second),
    .time_now      (time_now),
    .link_up       (link_up),
    .free          (free),
    .load          (load),
    .run           (run)
  );

  bded_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .run_in        (run),
    .free          (free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .intensity     (intensity),
    .deviation     (deviation),
    .flame_present (flame_present),
    .last_of_run   (last_of_run)
  );

  // An empty result register never holds back the input.
  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result register is empty");

  // The intensity report is always the final result of its run.
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == bded_pkg::KIND_REPORT) |-> last_of_run)
    else $error("intensity report not at the end of its run");

  // Once the last result is taken and nothing new is loaded, the output goes quiet.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run && !out_stall && !load |=> !out_valid)
    else $error("result valid after the end of a run");

  // A new run only enters when the result register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("run loaded over a pending result");

endmodule

@@ test/baseline_deviation_event_detector_tb.sv @@
// Testbench for the baseline deviation event detector, checked against a predictor.
`timescale 1ns / 1ps

module baseline_deviation_event_detector_tb;

  localparam int PRED        = -1;
  localparam int QUIET_LIMIT = 2000;
  localparam int PLAN_ROWS   = 18;

  typedef struct {
    logic        rtype;
    logic [11:0] s1;
    logic [11:0] s2;
    logic [31:0] now;
    logic        lk;
  } req_t;

  // A row with n_typed set to PRED is checked against the predictor only.
  typedef struct {
    req_t            req;
    int              n_typed;
    bded_pkg::kind_t kinds [3];
    logic [11:0]     lvl;
    logic [11:0]     dev;
    logic            flame;
  } row_t;

  typedef struct {
    bded_pkg::kind_t kind;
    logic [11:0]     lvl;
    logic [11:0]     dev;
    logic            flame;
    logic            last;
  } flame_evt_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [11:0] sample_first;
  logic [11:0] sample_second;
  logic [31:0] time_now;
  logic        link_up;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [11:0] intensity;
  logic [11:0] deviation;
  logic        flame_present;
  logic        last_of_run;

  baseline_deviation_event_detector u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .sample_first(sample_first), .sample_second(sample_second),
    .time_now(time_now), .link_up(link_up),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .intensity(intensity), .deviation(deviation),
    .flame_present(flame_present), .last_of_run(last_of_run)
  );

  // Predictor copy of the configuration and detector state.
  bded_pkg::cfg_t cfg;
  logic        st_prev_raw;
  logic        st_flame;
  logic        st_prev_link;
  logic [31:0] t_raw_change;
  logic [31:0] t_event;
  logic [31:0] t_detect;
  logic [31:0] t_report;
  logic [11:0] st_level;

  flame_evt_t  pending_events [$];
  row_t        plan [PLAN_ROWS];
  int          errors;
  int          quiet_cycles;
  bit          calm;
  bit          regime;
  logic        link_now;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int detector_step(input req_t r, output bded_pkg::kind_t ks [3],
                                       output logic [11:0] lvl, output logic [11:0] dv,
                                       output logic fl);
    logic [11:0] d1;
    logic [11:0] d2;
    logic        raw;
    int          n;
    n = 0;
    ks[0] = bded_pkg::KIND_REPORT;
    ks[1] = bded_pkg::KIND_REPORT;
    ks[2] = bded_pkg::KIND_REPORT;
    d1 = (r.s1 >= cfg.base_first) ? r.s1 - cfg.base_first : cfg.base_first - r.s1;
    d2 = (r.s2 >= cfg.base_second) ? r.s2 - cfg.base_second : cfg.base_second - r.s2;
    dv = (d1 >= d2) ? d1 : d2;
    lvl = (d1 >= d2) ? r.s1 : r.s2;
    raw = dv > cfg.threshold;
    if (!r.rtype) begin
      st_prev_raw = raw;
      st_flame = raw;
      t_report = r.now;
      t_detect = r.now;
      fl = st_flame;
      return 0;
    end
    if (r.lk && !st_prev_link) begin
      if (st_flame) begin
        ks[n] = bded_pkg::KIND_DETECTED;
        n = n + 1;
        t_detect = r.now;
      end else begin
        ks[n] = bded_pkg::KIND_CLEAR;
        n = n + 1;
      end
    end
    st_prev_link = r.lk;
    if (raw != st_prev_raw) begin
      st_prev_raw = raw;
      t_raw_change = r.now;
    end else if (32'(r.now - t_raw_change) >= {16'd0, cfg.debounce_time}) begin
      if (raw != st_flame) begin
        st_flame = raw;
        // Inside the event gap the state still flips, silently.
        if (32'(r.now - t_event) >= {16'd0, cfg.event_gap}) begin
          t_event = r.now;
          if (st_flame) begin
            ks[n] = bded_pkg::KIND_DETECTED;
            n = n + 1;
            t_detect = r.now;
          end else begin
            ks[n] = bded_pkg::KIND_CLEAR;
            n = n + 1;
          end
        end
      end else if (st_flame && 32'(r.now - t_detect) >= {16'd0, cfg.resend_period}) begin
        t_detect = r.now;
        ks[n] = bded_pkg::KIND_DETECTED;
        n = n + 1;
      end
    end
    if (32'(r.now - t_report) >= {16'd0, cfg.report_period}) begin
      t_report = r.now;
      st_level = lvl;
      ks[n] = bded_pkg::KIND_REPORT;
      n = n + 1;
    end
    fl = st_flame;
    return n;
  endfunction

  function automatic row_t mk_row(input logic t, input int s1, input int s2,
                                  input logic [31:0] now, input logic lk, input int n,
                                  input bded_pkg::kind_t k0, input int lvl, input int dv,
                                  input logic fl);
    row_t r;
    r.req = '{t, 12'(s1), 12'(s2), now, lk};
    r.n_typed = n;
    r.kinds[0] = k0;
    r.kinds[1] = bded_pkg::KIND_REPORT;
    r.kinds[2] = bded_pkg::KIND_REPORT;
    r.lvl = 12'(lvl);
    r.dev = 12'(dv);
    r.flame = fl;
    return r;
  endfunction

  function automatic logic [11:0] pick_sample(input int base, input int mag);
    if (($urandom_range(0, 1) == 1 && base >= mag) || base + mag > 4095)
      return (base >= mag) ? 12'(base - mag) : 12'd0;
    return 12'(base + mag);
  endfunction

  // Mostly well-formed sequences: flame and no-flame stretches with moving time.
  function automatic row_t make_item(input bit first);
    row_t r;
    int   thr;
    int   big;
    int   other;
    int   roll;
    r = mk_row(1'b1, 0, 0, 0, 1'b0, PRED, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    roll = $urandom_range(0, 49);
    if (roll == 0) clock_ms = $urandom();
    else if (roll < 5) clock_ms += $urandom_range(0, 6000);
    else if (roll < 20) clock_ms += $urandom_range(0, 700);
    else clock_ms += $urandom_range(0, 60);
    if ($urandom_range(0, 9) == 0) regime = ~regime;
    if ($urandom_range(0, 11) == 0) link_now = ~link_now;
    r.req.rtype = !(first || $urandom_range(0, 29) == 0);
    r.req.now = clock_ms;
    r.req.lk = link_now;
    if ($urandom_range(0, 9) == 0) begin
      r.req.s1 = 12'($urandom_range(0, 4095));
      r.req.s2 = 12'($urandom_range(0, 4095));
    end else begin
      thr = cfg.threshold;
      if (regime) begin
        big = thr + $urandom_range(1, 400);
        if (big > 4095) big = 4095;
      end else begin
        big = $urandom_range(0, thr);
      end
      other = ($urandom_range(0, 7) == 0) ? big : $urandom_range(0, big);
      if ($urandom_range(0, 1) == 1) begin
        r.req.s1 = pick_sample(cfg.base_first, big);
        r.req.s2 = pick_sample(cfg.base_second, other);
      end else begin
        r.req.s1 = pick_sample(cfg.base_first, other);
        r.req.s2 = pick_sample(cfg.base_second, big);
      end
    end
    return r;
  endfunction

  task automatic send_row(input row_t row);
    bded_pkg::kind_t ks [3];
    logic [11:0]     lvl;
    logic [11:0]     dv;
    logic            fl;
    int              n;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = row.req.rtype;
    sample_first = row.req.s1;
    sample_second = row.req.s2;
    time_now = row.req.now;
    link_up = row.req.lk;
    do @(posedge clk); while (in_stall !== 1'b0);
    n = detector_step(row.req, ks, lvl, dv, fl);
    if (row.n_typed != PRED) begin
      n = row.n_typed;
      ks = row.kinds;
      lvl = row.lvl;
      dv = row.dev;
      fl = row.flame;
    end
    for (int k = 0; k < n; k++) pending_events.push_back('{ks[k], lvl, dv, fl, k == n - 1});
  endtask

  task automatic write_reg(input bded_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      bded_pkg::REG_BASE_FIRST:    cfg.base_first = val[11:0];
      bded_pkg::REG_BASE_SECOND:   cfg.base_second = val[11:0];
      bded_pkg::REG_THRESHOLD:     cfg.threshold = val[11:0];
      bded_pkg::REG_DEBOUNCE_TIME: cfg.debounce_time = val[15:0];
      bded_pkg::REG_EVENT_GAP:     cfg.event_gap = val[15:0];
      bded_pkg::REG_RESEND_PERIOD: cfg.resend_period = val[15:0];
      bded_pkg::REG_REPORT_PERIOD: cfg.report_period = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(input int bf, input int bs, input int thr, input int deb,
                          input int gap, input int rsnd, input int rpt);
    write_reg(bded_pkg::REG_BASE_FIRST, bf);
    write_reg(bded_pkg::REG_BASE_SECOND, bs);
    write_reg(bded_pkg::REG_THRESHOLD, thr);
    write_reg(bded_pkg::REG_DEBOUNCE_TIME, deb);
    write_reg(bded_pkg::REG_EVENT_GAP, gap);
    write_reg(bded_pkg::REG_RESEND_PERIOD, rsnd);
    write_reg(bded_pkg::REG_REPORT_PERIOD, rpt);
  endtask

  // Drain every pending result, then give a request without results time to leave.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    flame_evt_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d level %0d dev %0d flame %0b last %0b",
                   kind, intensity, deviation, flame_present, last_of_run);
      end else begin
        want = pending_events.pop_front();
        if (kind !== want.kind || intensity !== want.lvl || deviation !== want.dev ||
            flame_present !== want.flame || last_of_run !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                     want.kind, want.lvl, want.dev, want.flame, want.last,
                     kind, intensity, deviation, flame_present, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    req_type = 1'b0;
    sample_first = '0;
    sample_second = '0;
    time_now = '0;
    link_up = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    regime = 1'b0;
    link_now = 1'b0;
    clock_ms = '0;
    cfg = '{12'd0, 12'd0, 12'd200, 16'd50, 16'd500, 16'd5000, 16'd1000};
    st_prev_raw = 1'b0;
    st_flame = 1'b0;
    st_prev_link = 1'b0;
    t_raw_change = '0;
    t_event = '0;
    t_detect = '0;
    t_report = '0;
    st_level = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Reset defaults: raw flag change, a flip inside the event gap, then the
    // periodic report, the link re-report and a clear event.
    plan[0]  = mk_row(1'b1, 0, 0, 32'd0, 1'b0, 0, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    plan[1]  = mk_row(1'b1, 4095, 0, 32'd10, 1'b0, 0, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    plan[2]  = mk_row(1'b1, 4095, 4095, 32'd70, 1'b0, 0, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    plan[3]  = mk_row(1'b1, 4095, 0, 32'd1000, 1'b0, 1, bded_pkg::KIND_REPORT, 4095, 4095,
                      1'b1);
    plan[4]  = mk_row(1'b1, 0, 0, 32'd1010, 1'b1, 1, bded_pkg::KIND_DETECTED, 0, 0, 1'b1);
    plan[5]  = mk_row(1'b1, 0, 0, 32'd1100, 1'b1, 1, bded_pkg::KIND_CLEAR, 0, 0, 1'b0);
    // Second channel dominant, then link re-report, change event and report at once.
    plan[6]  = mk_row(1'b1, 0, 4095, 32'd1200, 1'b0, PRED, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    plan[7]  = mk_row(1'b1, 0, 4095, 32'd2100, 1'b1, PRED, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    // Deviation equal to the threshold is not flame; one above is.
    plan[8]  = mk_row(1'b1, 200, 0, 32'd2200, 1'b1, PRED, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    plan[9]  = mk_row(1'b1, 201, 0, 32'd2300, 1'b1, PRED, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    plan[10] = mk_row(1'b1, 0, 201, 32'd2400, 1'b0, PRED, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    // Start requests never produce results; time wraps past zero afterwards.
    plan[11] = mk_row(1'b0, 0, 0, 32'hFFFF_FF00, 1'b0, 0, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    plan[12] = mk_row(1'b1, 0, 0, 32'hFFFF_FFFF, 1'b1, PRED, bded_pkg::KIND_REPORT, 0, 0,
                      1'b0);
    plan[13] = mk_row(1'b1, 0, 0, 32'h0000_02E8, 1'b1, PRED, bded_pkg::KIND_REPORT, 0, 0,
                      1'b0);
    plan[14] = mk_row(1'b0, 4095, 4095, 32'd1000, 1'b1, 0, bded_pkg::KIND_REPORT, 0, 0, 1'b0);
    plan[15] = mk_row(1'b1, 4095, 4095, 32'd7000, 1'b0, PRED, bded_pkg::KIND_REPORT, 0, 0,
                      1'b0);
    plan[16] = mk_row(1'b1, 4095, 4095, 32'd12100, 1'b1, PRED, bded_pkg::KIND_REPORT, 0, 0,
                      1'b0);
    plan[17] = mk_row(1'b1, 0, 4095, 32'hFFFF_FFFF, 1'b0, PRED, bded_pkg::KIND_REPORT, 0, 0,
                      1'b0);
    foreach (plan[i]) send_row(plan[i]);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: load_cfg(0, 0, 0, 0, 0, 0, 0);
        2: load_cfg(4095, 4095, 4095, 65535, 65535, 65535, 65535);
        default: load_cfg($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 1500), $urandom_range(0, 200),
                          $urandom_range(0, 1500), $urandom_range(0, 3000),
                          $urandom_range(0, 3000));
      endcase
      if (p == 5) calm = 1'b1;
      clock_ms = $urandom();
      for (int i = 0; i < 70; i++) send_row(make_item(i == 0));
      settle();
    end

    if (errors == 0 && pending_events.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
